// ===== rtl/sle_pkg.sv =====
// sle_pkg: types, codes and sizes shared by the sorted list engine
// no dependencies; imported by sle_ctrl, sle_dpath and sorted_list_engine
`timescale 1ns / 1ps

package sle_pkg;

    localparam int CAPACITY    = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        CMD_INSERT = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_FIND   = 3'd2,
        CMD_READ   = 3'd3,
        CMD_RANGE  = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_INVALID   = 3'd1,
        STAT_EMPTY     = 3'd2,
        STAT_BAD_RANGE = 3'd3,
        STAT_FULL      = 3'd4
    } stat_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_CAPTURE,
        S_SHUP_RD,
        S_SHUP_WR,
        S_SHDN_RD,
        S_SHDN_WR,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_POS,
        IDX_COUNT,
        IDX_INC,
        IDX_DEC
    } idx_op_t;

    typedef enum logic [1:0] {
        RD_IDX,
        RD_IDX_DEC,
        RD_IDX_N,
        RD_POS
    } rd_sel_t;

    typedef struct packed {
        logic [2:0]                    cmd;
        logic signed [VALUE_WIDTH-1:0] value;
        logic [IDX_W-1:0]              position;
        logic [IDX_W-1:0]              position_end;
    } req_t;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] result_value;
        logic                          found;
        logic [IDX_W-1:0]              found_position;
        logic [CNT_W-1:0]              entry_count;
        logic [2:0]                    status;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic    load_req;
        idx_op_t idx_op;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        logic    wr_value;
        logic    cnt_inc;
        logic    cnt_sub_n;
        logic    cap_result;
        logic    set_found;
        logic    set_status;
        stat_t   status;
        logic    publish;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [2:0] cmd;
        logic       full;
        logic       empty;
        logic       pos_bad;
        logic       range_bad;
        logic       end_bad;
        logic       scan_end;
        logic       precedes;
        logic       equal;
        logic       shup_more;
        logic       shdn_more;
    } dp_sts_t;

endpackage

// ===== rtl/sle_dpath.sv =====
// sle_dpath: entry memory, count, index counter and result registers
// depends on sle_pkg; driven by sle_ctrl commands
`timescale 1ns / 1ps

module sle_dpath (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_desc,
    input  sle_pkg::req_t    req,
    input  sle_pkg::dp_cmd_t cmd,
    output sle_pkg::dp_sts_t sts,
    output sle_pkg::rsp_t    rsp
);
    import sle_pkg::*;

    logic signed [VALUE_WIDTH-1:0] mem [CAPACITY];

    logic                          desc_reg;
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic [CNT_W-1:0]              idx_reg;
    logic [CNT_W-1:0]              idx_next;
    logic [CNT_W-1:0]              at_reg;
    logic [CNT_W-1:0]              at_next;
    req_t                          req_reg;
    logic signed [VALUE_WIDTH-1:0] rd_data_reg;
    logic signed [VALUE_WIDTH-1:0] res_value_reg;
    logic                          found_reg;
    logic [IDX_W-1:0]              fpos_reg;
    stat_t                         status_reg;
    rsp_t                          rsp_reg;

    logic [CNT_W-1:0]              span;
    logic [CNT_W:0]                idx_plus_n;
    logic [CNT_W-1:0]              idx_dec;
    logic [IDX_W-1:0]              rd_addr;
    logic signed [VALUE_WIDTH-1:0] wr_data;

    // entries dropped by a remove: one for remove at position, else the range length
    assign span = (req_reg.cmd == CMD_RANGE)
                ? ({1'b0, req_reg.position_end} - {1'b0, req_reg.position} + CNT_W'(1))
                : CNT_W'(1);
    assign idx_plus_n = {1'b0, idx_reg} + {1'b0, span};
    assign idx_dec    = idx_reg - CNT_W'(1);

    always_comb
    begin
        case (cmd.rd_sel)
            RD_IDX:     rd_addr = idx_reg[IDX_W-1:0];
            RD_IDX_DEC: rd_addr = idx_dec[IDX_W-1:0];
            RD_IDX_N:   rd_addr = idx_plus_n[IDX_W-1:0];
            RD_POS:     rd_addr = req_reg.position;
            default:    rd_addr = idx_reg[IDX_W-1:0];
        endcase
    end

    assign wr_data = cmd.wr_value ? req_reg.value : rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[idx_reg[IDX_W-1:0]] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        at_next  = at_reg;
        case (cmd.idx_op)
            IDX_ZERO:  idx_next = '0;
            IDX_POS:   idx_next = {1'b0, req_reg.position};
            IDX_COUNT:
            begin
                at_next  = idx_reg;
                idx_next = count_reg;
            end
            IDX_INC:   idx_next = idx_reg + CNT_W'(1);
            IDX_DEC:   idx_next = idx_dec;
            default:   idx_next = idx_reg;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.cnt_sub_n)
        begin
            count_next = count_reg - span;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desc_reg  <= 1'b0;
            count_reg <= '0;
            idx_reg   <= '0;
            at_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                desc_reg <= cfg_desc;
            end
            count_reg <= count_next;
            idx_reg   <= idx_next;
            at_reg    <= at_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg       <= req;
            res_value_reg <= '0;
            found_reg     <= 1'b0;
            fpos_reg      <= '0;
            status_reg    <= STAT_OK;
        end
        else
        begin
            if (cmd.cap_result)
            begin
                res_value_reg <= rd_data_reg;
            end
            if (cmd.set_found)
            begin
                found_reg <= 1'b1;
                fpos_reg  <= idx_reg[IDX_W-1:0];
            end
            if (cmd.set_status)
            begin
                status_reg <= cmd.status;
            end
        end
        if (cmd.publish)
        begin
            rsp_reg.result_value   <= res_value_reg;
            rsp_reg.found          <= found_reg;
            rsp_reg.found_position <= fpos_reg;
            rsp_reg.entry_count    <= count_reg;
            rsp_reg.status         <= status_reg;
        end
    end

    assign sts.cmd       = req_reg.cmd;
    assign sts.full      = (count_reg >= CNT_W'(CAPACITY));
    assign sts.empty     = (count_reg == '0);
    assign sts.pos_bad   = ({1'b0, req_reg.position} >= count_reg);
    assign sts.range_bad = (req_reg.position > req_reg.position_end);
    assign sts.end_bad   = ({1'b0, req_reg.position_end} >= count_reg);
    assign sts.scan_end  = (idx_reg == count_reg);
    assign sts.precedes  = desc_reg ? (req_reg.value >= rd_data_reg)
                                    : (req_reg.value <= rd_data_reg);
    assign sts.equal     = (req_reg.value == rd_data_reg);
    assign sts.shup_more = (idx_reg > at_reg);
    assign sts.shdn_more = (idx_plus_n < {1'b0, count_reg});

    assign rsp = rsp_reg;

endmodule

// ===== rtl/sle_ctrl.sv =====
// sle_ctrl: request sequencer for the sorted list engine
// depends on sle_pkg; commands sle_dpath and owns both handshakes
`timescale 1ns / 1ps

module sle_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    input  sle_pkg::dp_sts_t sts,
    output sle_pkg::dp_cmd_t cmd
);
    import sle_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req_stall  = 1'b1;
        cmd        = '0;
        cmd.idx_op = IDX_HOLD;
        cmd.rd_sel = RD_IDX;
        cmd.status = STAT_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end

            S_DECODE:
            begin
                unique case (sts.cmd)
                    CMD_INSERT:
                    begin
                        if (sts.full)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = STAT_FULL;
                            state_next     = S_DONE;
                        end
                        else
                        begin
                            cmd.idx_op = IDX_ZERO;
                            state_next = S_SCAN_RD;
                        end
                    end
                    CMD_FIND:
                    begin
                        cmd.idx_op = IDX_ZERO;
                        state_next = S_SCAN_RD;
                    end
                    CMD_REMOVE, CMD_READ:
                    begin
                        if (sts.pos_bad)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = STAT_INVALID;
                            state_next     = S_DONE;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_POS;
                            state_next = S_CAPTURE;
                        end
                    end
                    CMD_RANGE:
                    begin
                        if (sts.empty || sts.range_bad || sts.end_bad)
                        begin
                            cmd.set_status = 1'b1;
                            if (sts.empty)
                            begin
                                cmd.status = STAT_EMPTY;
                            end
                            else if (sts.range_bad)
                            begin
                                cmd.status = STAT_BAD_RANGE;
                            end
                            else
                            begin
                                cmd.status = STAT_INVALID;
                            end
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cmd.idx_op = IDX_POS;
                            state_next = S_SHDN_RD;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            // walk from the head: insert stops at the first entry the value goes before
            S_SCAN_RD:
            begin
                if (sts.scan_end)
                begin
                    if (sts.cmd == CMD_INSERT)
                    begin
                        cmd.idx_op = IDX_COUNT;
                        state_next = S_SHUP_RD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_IDX;
                    state_next = S_SCAN_CHK;
                end
            end

            S_SCAN_CHK:
            begin
                if (sts.cmd == CMD_INSERT)
                begin
                    if (sts.precedes)
                    begin
                        cmd.idx_op = IDX_COUNT;
                        state_next = S_SHUP_RD;
                    end
                    else
                    begin
                        cmd.idx_op = IDX_INC;
                        state_next = S_SCAN_RD;
                    end
                end
                else
                begin
                    if (sts.equal)
                    begin
                        cmd.set_found = 1'b1;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        cmd.idx_op = IDX_INC;
                        state_next = S_SCAN_RD;
                    end
                end
            end

            S_CAPTURE:
            begin
                cmd.cap_result = 1'b1;
                if (sts.cmd == CMD_REMOVE)
                begin
                    cmd.idx_op = IDX_POS;
                    state_next = S_SHDN_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            // open a gap at the insertion point, moving the tail up one word at a time
            S_SHUP_RD:
            begin
                if (sts.shup_more)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_IDX_DEC;
                    state_next = S_SHUP_WR;
                end
                else
                begin
                    cmd.wr_en    = 1'b1;
                    cmd.wr_value = 1'b1;
                    cmd.cnt_inc  = 1'b1;
                    state_next   = S_DONE;
                end
            end

            S_SHUP_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.idx_op = IDX_DEC;
                state_next = S_SHUP_RD;
            end

            // close the hole by pulling the tail down
            S_SHDN_RD:
            begin
                if (sts.shdn_more)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_IDX_N;
                    state_next = S_SHDN_WR;
                end
                else
                begin
                    cmd.cnt_sub_n = 1'b1;
                    state_next    = S_DONE;
                end
            end

            S_SHDN_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.idx_op = IDX_INC;
                state_next = S_SHDN_RD;
            end

            S_DONE:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.publish | (out_valid_reg & rsp_stall);
    assign rsp_valid      = out_valid_reg;

endmodule

// ===== rtl/sorted_list_engine.sv =====
// sorted_list_engine: top level of the sorted list engine
// depends on sle_pkg, sle_ctrl and sle_dpath
`timescale 1ns / 1ps

// Keeps up to 64 signed 32-bit entries in ascending or descending order (cfg_data,
// which the user must have written only while idle; the block does not enforce this)
// and serves one request at a time: insert, remove at position, find, read at
// position and remove range, each giving one response word with the entry count
// after the operation. All entries sit in a single memory with one read and one
// write port, and every scan or shift step is a read, then a write or compare.
// The engine takes the next request while its last response still waits in the
// output register.
module sorted_list_engine (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_data,
    input  logic          req_valid,
    output logic          req_stall,
    input  sle_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output sle_pkg::rsp_t rsp
);
    import sle_pkg::*;

    dp_cmd_t dp_cmd;
    dp_sts_t dp_sts;
    logic    cfg_we;

    // order register is a plain flop, always ready
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid & cfg_ready;

    sle_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (dp_sts),
        .cmd       (dp_cmd)
    );

    sle_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_desc (cfg_data),
        .req      (req),
        .cmd      (dp_cmd),
        .sts      (dp_sts),
        .rsp      (rsp)
    );

endmodule
